FILE: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/fpqc_pkg.sv
package fpqc_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FWD_THRESH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 1'd1;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_LOOKUP = 3'd1;
    localparam logic [2:0] KIND_SEEK   = 3'd2;
    localparam logic [2:0] KIND_PLAY   = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;
    localparam logic [2:0] KIND_EOS    = 3'd5;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_EARLIER = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] frame_number;
        logic               number_valid;
        logic [7:0]         payload_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_frame;
        logic [7:0]         found_handle;
        logic               decode_request;
        logic               seek_request;
        logic signed [31:0] seek_frame;
        logic               rewind_request;
        logic [3:0]         entry_count;
        logic signed [31:0] oldest_frame;
        logic signed [31:0] newest_frame;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_TICK_NEWEST,
        S_TICK_FWD,
        S_TICK_TRIM,
        S_TICK_PACK,
        S_FIN_OLD,
        S_FIN_NEW,
        S_OUT
    } state_t;

endpackage

FILE: hdl/frame_prefetch_queue_controller_core.sv
// Frame prefetch queue: sorted store of up to QUEUE_DEPTH frames in two small RAMs.
// One command is taken when start is high and busy is low; busy stays high until the
// result beat, marked by done for one cycle, which the receiver must take since it
// cannot stall. Insert, lookup and tick walk the store one entry per cycle with one
// shared 34-bit compare unit, so for them the count of held entries sets how long
// busy stays high; the other commands only pass the finish states. done rises in the
// same cycle that busy falls.
module frame_prefetch_queue_controller_core #(
    parameter int QUEUE_DEPTH = fpqc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fpqc_pkg::in_item_t        cmd,
    output logic                      done,
    output fpqc_pkg::out_item_t       result,
    input  logic                      cfg_we,
    input  logic [fpqc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpqc_pkg::CFG_W-1:0]     cfg_data
);
    import fpqc_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int HW = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    out_item_t res_reg, res_next;
    logic done_reg, done_next;

    logic [15:0] thresh_reg, thresh_next;
    logic loop_reg, loop_next;
    logic [HW-1:0] held_reg, held_next;
    logic signed [31:0] play_reg, play_next;
    logic signed [31:0] last_reg, last_next;
    logic hold_reg, hold_next;
    logic pend_reg, pend_next;
    logic signed [31:0] pend_frame_reg, pend_frame_next;

    logic [HW-1:0] idx_reg, idx_next;
    logic [HW-1:0] pos_reg, pos_next;
    logic [HW-1:0] drop_reg, drop_next;
    logic hit_reg, hit_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] old_reg, old_next;

    logic tag_we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] tag_wdata, tag_rdata;
    logic [7:0] h_wdata, h_rdata;

    logic signed [33:0] ca, cb;
    logic c_lt, c_eq;

    fpqc_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_tags (
        .clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wdata),
        .raddr(raddr), .rdata(tag_rdata)
    );

    fpqc_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_handles (
        .clk(clk), .we(tag_we), .waddr(waddr), .wdata(h_wdata),
        .raddr(raddr), .rdata(h_rdata)
    );

    fpqc_cmp u_cmp (.a(ca), .b(cb), .lt(c_lt), .eq(c_eq));

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            thresh_reg     <= 16'd16;
            loop_reg       <= 1'b0;
            held_reg       <= '0;
            play_reg       <= '0;
            last_reg       <= -32'sd1;
            hold_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            pend_frame_reg <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            drop_reg       <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            thresh_reg     <= thresh_next;
            loop_reg       <= loop_next;
            held_reg       <= held_next;
            play_reg       <= play_next;
            last_reg       <= last_next;
            hold_reg       <= hold_next;
            pend_reg       <= pend_next;
            pend_frame_reg <= pend_frame_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            drop_reg       <= drop_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        key_reg  <= key_next;
        old_reg  <= old_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        thresh_next     = thresh_reg;
        loop_next       = loop_reg;
        held_next       = held_reg;
        play_next       = play_reg;
        last_next       = last_reg;
        hold_next       = hold_reg;
        pend_next       = pend_reg;
        pend_frame_next = pend_frame_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        drop_next       = drop_reg;
        hit_next        = hit_reg;
        key_next        = key_reg;
        old_next        = old_reg;
        tag_we          = 1'b0;
        waddr           = idx_reg[AW-1:0];
        raddr           = idx_reg[AW-1:0];
        tag_wdata       = key_reg;
        h_wdata         = item_reg.payload_handle;
        ca              = 34'(tag_rdata);
        cb              = 34'(key_reg);

        if (cfg_we)
        begin
            if (cfg_index == CFG_FWD_THRESH)
            begin
                thresh_next = cfg_data;
            end
            else
            begin
                loop_next = cfg_data[0];
                if (cfg_data[0])
                begin
                    hold_next = 1'b0;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = cmd;
                    res_next  = '0;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    pos_next  = held_reg;
                    drop_next = '0;
                    raddr     = '0;
                    unique case (cmd.kind)
                        KIND_INSERT:
                        begin
                            key_next  = cmd.number_valid ? cmd.frame_number : last_reg + 32'sd1;
                            last_next = key_next;
                            state_next = S_SCAN;
                        end
                        KIND_LOOKUP:
                        begin
                            key_next   = cmd.frame_number;
                            play_next  = cmd.frame_number;
                            res_next.status = ST_MISS;
                            state_next = S_SCAN;
                        end
                        KIND_SEEK:
                        begin
                            pend_frame_next = cmd.frame_number;
                            pend_next  = 1'b1;
                            hold_next  = 1'b0;
                            held_next  = '0;
                            play_next  = cmd.frame_number;
                            last_next  = -32'sd1;
                            state_next = S_FIN_OLD;
                        end
                        KIND_PLAY:
                        begin
                            play_next  = cmd.frame_number;
                            state_next = S_FIN_OLD;
                        end
                        KIND_TICK:
                        begin
                            state_next = S_TICK_NEWEST;
                            if (pend_reg)
                            begin
                                pend_next = 1'b0;
                                hold_next = 1'b0;
                                res_next.seek_request = 1'b1;
                                res_next.seek_frame   = pend_frame_reg;
                                last_next = pend_frame_reg - 32'sd1;
                            end
                        end
                        KIND_EOS:
                        begin
                            if (loop_reg)
                            begin
                                res_next.rewind_request = 1'b1;
                                last_next = -32'sd1;
                            end
                            else
                            begin
                                hold_next = 1'b1;
                            end
                            state_next = S_FIN_OLD;
                        end
                        default:
                        begin
                            state_next = S_FIN_OLD;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // tag_rdata holds entry idx_reg
                if (idx_reg >= held_reg || hit_reg)
                begin
                    if (item_reg.kind == KIND_LOOKUP)
                    begin
                        state_next = S_FIN_OLD;
                    end
                    else if (hit_reg && pos_reg < held_reg && res_reg.status == ST_HIT)
                    begin
                        waddr     = pos_reg[AW-1:0];
                        tag_we    = 1'b1;
                        res_next.status = ST_DONE;
                        state_next = S_FIN_OLD;
                    end
                    else if (held_reg >= HW'(QUEUE_DEPTH))
                    begin
                        res_next.status = ST_DROPPED;
                        state_next = S_FIN_OLD;
                    end
                    else
                    begin
                        idx_next   = held_reg;
                        raddr      = AW'(held_reg - HW'(1));
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    if (item_reg.kind == KIND_LOOKUP)
                    begin
                        if (c_lt || c_eq)
                        begin
                            res_next.status       = c_eq ? ST_HIT : ST_EARLIER;
                            res_next.found_frame  = tag_rdata;
                            res_next.found_handle = h_rdata;
                        end
                        idx_next = idx_reg + HW'(1);
                        raddr    = AW'(idx_reg + HW'(1));
                    end
                    else if (c_eq || !c_lt)
                    begin
                        hit_next = 1'b1;
                        pos_next = idx_reg;
                        res_next.status = c_eq ? ST_HIT : ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + HW'(1);
                        raddr    = AW'(idx_reg + HW'(1));
                    end
                end
            end

            S_SHIFT:
            begin
                // idx_reg is the slot to fill, tag_rdata holds idx_reg-1
                res_next.status = ST_DONE;
                if (idx_reg == pos_reg)
                begin
                    tag_we    = 1'b1;
                    held_next = held_reg + HW'(1);
                    state_next = S_FIN_OLD;
                end
                else
                begin
                    tag_we    = 1'b1;
                    tag_wdata = tag_rdata;
                    h_wdata   = h_rdata;
                    idx_next  = idx_reg - HW'(1);
                    raddr     = AW'(idx_reg - HW'(2));
                end
            end

            S_TICK_NEWEST:
            begin
                // entry 0 on tag_rdata, backward jump check
                state_next = S_TICK_FWD;
                if (held_reg != '0)
                begin
                    ca = 34'(tag_rdata);
                    cb = 34'(play_reg) + 34'(QUEUE_DEPTH) + 34'sd1;
                    if (!c_lt)
                    begin
                        held_next = '0;
                        pend_frame_next = play_reg;
                        pend_next = 1'b1;
                        last_next = -32'sd1;
                        hold_next = 1'b0;
                        state_next = S_FIN_OLD;
                    end
                end
                else
                begin
                    ca = 34'(play_reg);
                    cb = 34'(last_reg) - 34'(QUEUE_DEPTH);
                    if (!last_reg[31] && c_lt)
                    begin
                        pend_frame_next = play_reg;
                        pend_next = 1'b1;
                        last_next = -32'sd1;
                        state_next = S_FIN_OLD;
                    end
                end
            end

            S_TICK_FWD:
            begin
                // forward jump check, fetch newest
                ca = 34'(last_reg) + 34'(thresh_reg);
                cb = 34'(play_reg);
                raddr = AW'(held_reg - HW'(1));
                state_next = S_TICK_TRIM;
                if (!last_reg[31] && c_lt)
                begin
                    held_next = '0;
                    pend_frame_next = play_reg;
                    pend_next = 1'b1;
                    last_next = -32'sd1;
                    hold_next = 1'b0;
                    state_next = S_FIN_OLD;
                end
            end

            S_TICK_TRIM:
            begin
                // newest on tag_rdata, decode decision
                ca = 34'(tag_rdata);
                cb = 34'(play_reg) + 34'(QUEUE_DEPTH);
                if (!(hold_reg && !loop_reg) && held_reg < HW'(QUEUE_DEPTH)
                    && (held_reg == '0 || tag_rdata[31] || c_lt))
                begin
                    res_next.decode_request = 1'b1;
                end
                idx_next   = '0;
                raddr      = '0;
                state_next = S_TICK_PACK;
                hit_next   = 1'b0;
            end

            S_TICK_PACK:
            begin
                // first pass counts drops, second moves entries down
                if (!hit_reg)
                begin
                    ca = 34'(tag_rdata);
                    cb = 34'(play_reg) - 34'sd2;
                    if (drop_reg < held_reg && c_lt)
                    begin
                        drop_next = drop_reg + HW'(1);
                        raddr     = AW'(drop_reg + HW'(1));
                    end
                    else if (drop_reg == '0)
                    begin
                        state_next = S_FIN_OLD;
                    end
                    else
                    begin
                        hit_next = 1'b1;
                        idx_next = '0;
                        raddr    = AW'(drop_reg);
                    end
                end
                else
                begin
                    if (idx_reg + drop_reg >= held_reg)
                    begin
                        held_next  = held_reg - drop_reg;
                        state_next = S_FIN_OLD;
                    end
                    else
                    begin
                        tag_we    = 1'b1;
                        tag_wdata = tag_rdata;
                        h_wdata   = h_rdata;
                        idx_next  = idx_reg + HW'(1);
                        raddr     = AW'(idx_reg + drop_reg + HW'(1));
                    end
                end
            end

            S_FIN_OLD:
            begin
                raddr      = '0;
                state_next = S_FIN_NEW;
            end

            S_FIN_NEW:
            begin
                old_next   = tag_rdata;
                raddr      = AW'(held_reg - HW'(1));
                state_next = S_OUT;
            end

            S_OUT:
            begin
                res_next.entry_count  = 4'(held_reg);
                res_next.oldest_frame = (held_reg == '0) ? -32'sd1 : old_reg;
                res_next.newest_frame = (held_reg == '0) ? -32'sd1 : tag_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, state_reg == S_IDLE)
    `ASSERT_IMPL(a_held_bound, clk, rst_n, 1'b1, held_reg <= HW'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_out_leads_done, clk, rst_n, state_reg == S_OUT, done)
endmodule

FILE: hdl/fpqc_ram.sv
module fpqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

FILE: hdl/fpqc_cmp.sv
module fpqc_cmp (
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic               lt,
    output logic               eq
);
    logic signed [34:0] diff;

    assign diff = 35'(a) - 35'(b);
    assign lt   = diff[34];
    assign eq   = (a == b);
endmodule
